/* design/vlcs_pkg.sv */
package vlcs_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PROGRAM = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TOTAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_LAST      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADJUST_LAST    = 3'd4;

    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] SETTLE_TICKS_RST   = 16'd300;
    localparam logic [15:0] SAMPLE_TOTAL_RST   = 16'd1000;
    localparam logic [15:0] LOCK_THRESHOLD_RST = 16'd500;
    localparam logic [3:0]  BIAS_LAST_RST      = 4'd14;
    localparam logic [1:0]  ADJUST_LAST_RST    = 2'd3;

    // Default depth of the result queue; it must hold at least two results.
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic opcode;
        logic lock_sample;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  pt_bias;
        logic [1:0]  pt_adjust;
        logic        locked;
        logic [15:0] lock_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [15:0] sample_total;
        logic [15:0] lock_threshold;
        logic [3:0]  bias_last;
        logic [1:0]  adjust_last;
    } t_cfg;

    // Results caused by one accepted item: num is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] num;
        t_out       res0;
        t_out       res1;
    } t_push;

endpackage

/* design/vlcs_core.sv */
module vlcs_core
    import vlcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_in   i_in,
    input  t_cfg  i_cfg,
    output t_push o_push
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_SETTLE = 3'b010,
        PH_SAMPLE = 3'b100
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [15:0] r_wait,    n_wait;
    logic [15:0] r_samples, n_samples;
    logic [15:0] r_qual,    n_qual;
    logic [3:0]  r_bias,    n_bias;
    logic [1:0]  r_adj,     n_adj;

    logic [15:0] qual_upd;
    logic [15:0] samples_upd;
    logic [15:0] wait_dec;
    t_phase      begin_phase;

    always_comb begin
        qual_upd    = r_qual;
        samples_upd = r_samples;
        wait_dec    = r_wait - 16'd1;
        begin_phase = (i_cfg.settle_ticks == 16'd0) ? PH_SAMPLE : PH_SETTLE;

        n_phase   = r_phase;
        n_wait    = r_wait;
        n_samples = r_samples;
        n_qual    = r_qual;
        n_bias    = r_bias;
        n_adj     = r_adj;
        o_push    = '0;

        if (i_in.lock_sample) begin
            if (r_qual != 16'hFFFF) qual_upd = r_qual + 16'd1;
        end else if (r_qual != 16'd0) begin
            qual_upd = r_qual - 16'd1;
        end
        if (r_samples != 16'hFFFF) samples_upd = r_samples + 16'd1;

        if (!i_in.opcode) begin
            // Start: restart the sweep at the first point.
            n_bias    = '0;
            n_adj     = '0;
            n_samples = '0;
            n_qual    = '0;
            n_wait    = i_cfg.settle_ticks;
            n_phase   = begin_phase;
            o_push.num       = 2'd1;
            o_push.res0      = '0;
            o_push.res0.kind = KIND_PROGRAM;
            o_push.res0.last = 1'b1;
        end else begin
            unique case (r_phase)
                PH_SETTLE: begin
                    n_wait = wait_dec;
                    if (wait_dec == 16'd0) n_phase = PH_SAMPLE;
                end
                PH_SAMPLE: begin
                    n_qual    = qual_upd;
                    n_samples = samples_upd;
                    if (samples_upd >= i_cfg.sample_total) begin
                        o_push.num             = 2'd2;
                        o_push.res0.kind       = KIND_VERDICT;
                        o_push.res0.pt_bias    = r_bias;
                        o_push.res0.pt_adjust  = r_adj;
                        o_push.res0.locked     = (qual_upd > i_cfg.lock_threshold);
                        o_push.res0.lock_count = qual_upd;
                        o_push.res0.last       = 1'b0;
                        o_push.res1.last       = 1'b1;
                        if (r_adj < i_cfg.adjust_last || r_bias < i_cfg.bias_last) begin
                            if (r_adj < i_cfg.adjust_last) begin
                                n_adj = r_adj + 2'd1;
                            end else begin
                                n_adj  = '0;
                                n_bias = r_bias + 4'd1;
                            end
                            n_samples = '0;
                            n_qual    = '0;
                            n_wait    = i_cfg.settle_ticks;
                            n_phase   = begin_phase;
                            o_push.res1.kind      = KIND_PROGRAM;
                            o_push.res1.pt_bias   = n_bias;
                            o_push.res1.pt_adjust = n_adj;
                        end else begin
                            n_phase   = PH_IDLE;
                            n_wait    = '0;
                            n_samples = '0;
                            o_push.res1.kind = KIND_DONE;
                        end
                    end
                end
                default: begin
                    // Idle: ticks are ignored.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_wait    <= '0;
            r_samples <= '0;
            r_qual    <= '0;
            r_bias    <= '0;
            r_adj     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_wait    <= n_wait;
            r_samples <= n_samples;
            r_qual    <= n_qual;
            r_bias    <= n_bias;
            r_adj     <= n_adj;
        end
    end

endmodule

/* design/vlcs_outq.sv */
module vlcs_outq
    import vlcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_en,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(QUEUE_DEPTH - 2);

    t_out          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] wr_next;
    logic [1:0]    push_num;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    assign wr_next  = ptr_inc(r_wr);
    assign push_num = i_push_en ? i_push.num : 2'd0;
    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_cnt != '0);
    assign o_room   = (r_cnt <= ROOM_MAX);
    assign o_data   = r_mem[r_rd];

    always_comb begin
        n_rd  = pop ? ptr_inc(r_rd) : r_rd;
        n_wr  = r_wr;
        if (push_num == 2'd1) n_wr = wr_next;
        if (push_num == 2'd2) n_wr = ptr_inc(wr_next);
        n_cnt = r_cnt + CW'(push_num) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) r_mem[r_wr]    <= i_push.res0;
        if (push_num == 2'd2) r_mem[wr_next] <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* design/vco_lock_calibration_sweep_top.sv */
// VCO lock calibration sweep. Each start transfer (opcode 0) restarts the sweep at
// bias 0, adjust 0 and yields a program request; each tick transfer (opcode 1) waits
// out the settling time and then takes one lock-detect sample, qualified by an
// up-down counter that stops at zero and saturates at its top. After the last sample
// of a point the block yields a verdict, followed by the next program request or a
// done marker. Ticks while idle are ignored. An input transfer is taken in the cycle
// it is offered as long as the result queue has room for two results, so the block
// accepts one item per cycle; its results are registered in the result queue and leave
// it one per cycle while the receiver is ready, and the output channel's rate of one
// result per cycle is what bounds the input rate when results pile up. Configuration
// writes take effect at once and should be made while no sweep is running.
module vco_lock_calibration_sweep_top
    import vlcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_push push;
    logic  accept;
    logic  room;

    // Configuration registers. Writes to unlisted indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks   <= SETTLE_TICKS_RST;
            r_cfg.sample_total   <= SAMPLE_TOTAL_RST;
            r_cfg.lock_threshold <= LOCK_THRESHOLD_RST;
            r_cfg.bias_last      <= BIAS_LAST_RST;
            r_cfg.adjust_last    <= ADJUST_LAST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SETTLE_TICKS:   r_cfg.settle_ticks   <= i_cfg_data[15:0];
                REG_SAMPLE_TOTAL:   r_cfg.sample_total   <= i_cfg_data[15:0];
                REG_LOCK_THRESHOLD: r_cfg.lock_threshold <= i_cfg_data[15:0];
                REG_BIAS_LAST:      r_cfg.bias_last      <= i_cfg_data[3:0];
                REG_ADJUST_LAST:    r_cfg.adjust_last    <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // The queue must have room for the two results one transfer can cause.
    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    vlcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in_data),
        .i_cfg    (r_cfg),
        .o_push   (push)
    );

    vlcs_outq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (push),
        .o_room    (room),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule

/* sim/vco_lock_calibration_sweep_top_tb.sv */
module vco_lock_calibration_sweep_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vlcs_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 6;
    // Cycles without any transfer before the run is declared hung. The longest
    // legal quiet stretch is the receiver hold-off plus a register write.
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // Ticks can finish without a result, so a few spare cycles are allowed
    // after the last expected result before the registers are touched.
    localparam int DRAIN_CYCLES    = 10;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int PHASE_ITEMS     = 150;
    localparam int MAX_REPORTS     = 10;
    // Marks a directed row whose results come from the predictor.
    localparam int PREDICTED       = -1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_SAMPLE = 2'd2
    } t_sweep_phase;

    typedef enum logic {
        ROW_ITEM,
        ROW_CONFIG
    } t_row_kind;

    // One line of the directed table: either a register setting or one item,
    // optionally with its results typed in by hand.
    typedef struct {
        t_row_kind kind;
        t_cfg      cfg;
        t_in       item;
        int        n_typed;
        t_out      r0;
        t_out      r1;
    } t_dir_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = REG_SETTLE_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the sweep state and of the register file.
    t_cfg         sweep_cfg;
    t_sweep_phase sweep_phase  = PH_IDLE;
    logic [15:0]  settle_left  = '0;
    logic [15:0]  samples_seen = '0;
    logic [15:0]  qual_count   = '0;
    logic [3:0]   cur_bias     = '0;
    logic [1:0]   cur_adjust   = '0;

    t_out     pending_results[$];
    t_dir_row directed_rows[$];

    // Shared knobs: burst_mode removes all idling on both sides, and
    // hold_off_req asks the receiver for one long stall.
    bit burst_mode     = 1'b0;
    bit hold_off_req   = 1'b0;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    vco_lock_calibration_sweep_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    function automatic t_cfg make_cfg(logic [15:0] settle, logic [15:0] total,
                                      logic [15:0] thresh, logic [3:0] bias_top,
                                      logic [1:0] adjust_top);
        t_cfg c;
        c.settle_ticks   = settle;
        c.sample_total   = total;
        c.lock_threshold = thresh;
        c.bias_last      = bias_top;
        c.adjust_last    = adjust_top;
        return c;
    endfunction

    function automatic t_in make_item(logic op, logic smp);
        t_in it;
        it.opcode      = op;
        it.lock_sample = smp;
        return it;
    endfunction

    function automatic t_out make_result(logic [1:0] kind, logic [3:0] bias,
                                         logic [1:0] adjust, logic lk,
                                         logic [15:0] cnt, logic is_last);
        t_out r;
        r.kind       = kind;
        r.pt_bias    = bias;
        r.pt_adjust  = adjust;
        r.locked     = lk;
        r.lock_count = cnt;
        r.last       = is_last;
        return r;
    endfunction

    function automatic t_out prog_result(logic [3:0] bias, logic [1:0] adjust);
        return make_result(KIND_PROGRAM, bias, adjust, 1'b0, 16'd0, 1'b1);
    endfunction

    function automatic t_out verdict_result(logic [3:0] bias, logic [1:0] adjust,
                                            logic lk, logic [15:0] cnt);
        return make_result(KIND_VERDICT, bias, adjust, lk, cnt, 1'b0);
    endfunction

    function automatic t_out done_result();
        return make_result(KIND_DONE, 4'd0, 2'd0, 1'b0, 16'd0, 1'b1);
    endfunction

    function automatic void add_item(logic op, logic smp, int n_typed = PREDICTED,
                                     t_out r0 = '0, t_out r1 = '0);
        t_dir_row row;
        row.kind    = ROW_ITEM;
        row.cfg     = '0;
        row.item    = make_item(op, smp);
        row.n_typed = n_typed;
        row.r0      = r0;
        row.r1      = r1;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_config(t_cfg c);
        t_dir_row row;
        row.kind    = ROW_CONFIG;
        row.cfg     = c;
        row.item    = '0;
        row.n_typed = 0;
        row.r0      = '0;
        row.r1      = '0;
        directed_rows.push_back(row);
    endfunction

    // Arms a new sweep point: counters cleared, settling time loaded. With no
    // settling time the very next tick is already a sample.
    function automatic void open_point();
        samples_seen = '0;
        qual_count   = '0;
        settle_left  = sweep_cfg.settle_ticks;
        sweep_phase  = (sweep_cfg.settle_ticks == 16'd0) ? PH_SAMPLE : PH_SETTLE;
    endfunction

    // Advances the sweep by one accepted item and returns how many results it
    // causes (0, 1 or 2) in r0 and r1.
    function automatic int advance_sweep(input t_in it, output t_out r0,
                                         output t_out r1);
        logic more;
        r0 = '0;
        r1 = '0;
        if (it.opcode == OP_START) begin
            // A start always restarts from the first point, even mid-sweep.
            cur_bias   = '0;
            cur_adjust = '0;
            open_point();
            r0 = prog_result(cur_bias, cur_adjust);
            return 1;
        end
        if (sweep_phase == PH_SETTLE) begin
            settle_left = settle_left - 16'd1;
            if (settle_left == 16'd0) begin
                sweep_phase = PH_SAMPLE;
            end
            return 0;
        end
        if (sweep_phase != PH_SAMPLE) begin
            return 0;
        end

        // Up-down qualifier: floors at zero, saturates at its top.
        if (it.lock_sample) begin
            if (qual_count != 16'hFFFF) begin
                qual_count = qual_count + 16'd1;
            end
        end else if (qual_count != 16'd0) begin
            qual_count = qual_count - 16'd1;
        end
        if (samples_seen != 16'hFFFF) begin
            samples_seen = samples_seen + 16'd1;
        end
        // A sample total of zero behaves as one, and a total lowered below the
        // samples already taken ends the point here.
        if (samples_seen < sweep_cfg.sample_total) begin
            return 0;
        end

        r0 = verdict_result(cur_bias, cur_adjust,
                            qual_count > sweep_cfg.lock_threshold, qual_count);
        // Limits compare with "below", so limits lowered mid-sweep end the
        // inner or outer loop at once.
        more = 1'b1;
        if (cur_adjust < sweep_cfg.adjust_last) begin
            cur_adjust = cur_adjust + 2'd1;
        end else if (cur_bias < sweep_cfg.bias_last) begin
            cur_adjust = '0;
            cur_bias   = cur_bias + 4'd1;
        end else begin
            more = 1'b0;
        end

        if (more) begin
            open_point();
            r1 = prog_result(cur_bias, cur_adjust);
        end else begin
            sweep_phase  = PH_IDLE;
            settle_left  = '0;
            samples_seen = '0;
            r1 = done_result();
        end
        return 2;
    endfunction

    task automatic report_mismatch(input string what, input t_out want, input t_out got);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] %s: expected kind=%0d bias=%0d adjust=%0d locked=%0b count=%0d last=%0b",
                     $realtime, what, want.kind, want.pt_bias, want.pt_adjust,
                     want.locked, want.lock_count, want.last);
            $display("    got kind=%0d bias=%0d adjust=%0d locked=%0b count=%0d last=%0b",
                     got.kind, got.pt_bias, got.pt_adjust, got.locked,
                     got.lock_count, got.last);
        end
        mismatch_count++;
    endtask

    // Offers one item after a random gap and holds it until the transfer. The
    // predictor steps at the accepting edge; typed rows replace its results.
    task automatic send_item(input t_in it, input int n_typed = PREDICTED,
                             input t_out t0 = '0, input t_out t1 = '0);
        int   gap;
        int   n;
        t_out p0;
        t_out p1;
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!(in_valid && in_ready));
        n = advance_sweep(it, p0, p1);
        if (n_typed != PREDICTED) begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0) begin
            pending_results.push_back(p0);
        end
        if (n > 1) begin
            pending_results.push_back(p1);
        end
    endtask

    // Stops offering items and lets every outstanding result drain, plus a few
    // cycles for a tick that may still be in flight without a result.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers on consecutive edges; the write enable stays
    // high across them.
    task automatic write_config(input t_cfg c);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_SETTLE_TICKS;
        cfg_data <= c.settle_ticks;
        @(posedge clk);
        cfg_idx  <= REG_SAMPLE_TOTAL;
        cfg_data <= c.sample_total;
        @(posedge clk);
        cfg_idx  <= REG_LOCK_THRESHOLD;
        cfg_data <= c.lock_threshold;
        @(posedge clk);
        cfg_idx  <= REG_BIAS_LAST;
        cfg_data <= CFG_DATA_W'(c.bias_last);
        @(posedge clk);
        cfg_idx  <= REG_ADJUST_LAST;
        cfg_data <= CFG_DATA_W'(c.adjust_last);
        @(posedge clk);
        cfg_we   <= 1'b0;
        sweep_cfg = c;
    endtask

    // Random settings lean toward short points and small sweeps so that many
    // verdicts and done markers come out, with the extremes mixed in.
    function automatic t_cfg draw_config();
        t_cfg c;
        int   pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            c.settle_ticks = 16'hFFFF;
        end else if (pick < 6) begin
            c.settle_ticks = 16'd0;
        end else begin
            c.settle_ticks = 16'($urandom_range(1, 6));
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            c.sample_total = 16'd0;
        end else if (pick < 4) begin
            c.sample_total = 16'd1;
        end else begin
            c.sample_total = 16'($urandom_range(2, 10));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            c.lock_threshold = 16'd0;
        end else if (pick == 1) begin
            c.lock_threshold = 16'hFFFF;
        end else begin
            c.lock_threshold = 16'($urandom_range(0, c.sample_total));
        end
        c.bias_last   = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                                   : 4'($urandom_range(0, 15));
        c.adjust_last = 2'($urandom_range(0, 3));
        return c;
    endfunction

    // Every result transfer is checked against the oldest expectation.
    always @(posedge clk) begin : result_check
        t_out  want;
        string bad;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", '0, out_data);
            end else begin
                want = pending_results.pop_front();
                bad  = "";
                if (out_data.kind !== want.kind) begin
                    bad = {bad, " kind"};
                end
                if (out_data.pt_bias !== want.pt_bias) begin
                    bad = {bad, " pt_bias"};
                end
                if (out_data.pt_adjust !== want.pt_adjust) begin
                    bad = {bad, " pt_adjust"};
                end
                if (out_data.locked !== want.locked) begin
                    bad = {bad, " locked"};
                end
                if (out_data.lock_count !== want.lock_count) begin
                    bad = {bad, " lock_count"};
                end
                if (out_data.last !== want.last) begin
                    bad = {bad, " last"};
                end
                if (bad != "") begin
                    report_mismatch({"wrong", bad}, want, out_data);
                end
            end
        end
    end

    // Watchdog: any transfer on either channel resets the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result side: a random stall before each transfer, or one long hold-off
    // on request so that the result queue fills and the input stalls.
    initial begin : receiver
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                gap          = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (burst_mode) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin : stimulus
        int   counted;
        int   phase_count;
        int   lock_pct;
        logic op;
        logic smp;

        sweep_cfg = make_cfg(SETTLE_TICKS_RST, SAMPLE_TOTAL_RST, LOCK_THRESHOLD_RST,
                             BIAS_LAST_RST, ADJUST_LAST_RST);

        // Ticks with no sweep running are ignored; then a start under the
        // reset settings, followed by one tick that only settles.
        add_item(OP_TICK, 1'b1, 0);
        add_item(OP_TICK, 1'b0, 0);
        add_item(OP_START, 1'b1, 1, prog_result(4'd0, 2'd0));
        add_item(OP_TICK, 1'b1, 0);
        // No settling and a zero sample total: each tick closes a point, so a
        // two-by-two sweep finishes in four ticks.
        add_config(make_cfg(16'd0, 16'd0, 16'd0, 4'd1, 2'd1));
        add_item(OP_START, 1'b0, 1, prog_result(4'd0, 2'd0));
        add_item(OP_TICK, 1'b1, 2, verdict_result(4'd0, 2'd0, 1'b1, 16'd1),
                 prog_result(4'd0, 2'd1));
        add_item(OP_TICK, 1'b0, 2, verdict_result(4'd0, 2'd1, 1'b0, 16'd0),
                 prog_result(4'd1, 2'd0));
        add_item(OP_TICK, 1'b1, 2, verdict_result(4'd1, 2'd0, 1'b1, 16'd1),
                 prog_result(4'd1, 2'd1));
        add_item(OP_TICK, 1'b0, 2, verdict_result(4'd1, 2'd1, 1'b0, 16'd0),
                 done_result());
        add_item(OP_TICK, 1'b1, 0);
        // A second start in the middle of a sweep begins again at the origin.
        add_item(OP_START, 1'b1, 1, prog_result(4'd0, 2'd0));
        add_item(OP_TICK, 1'b1, 2, verdict_result(4'd0, 2'd0, 1'b1, 16'd1),
                 prog_result(4'd0, 2'd1));
        add_item(OP_START, 1'b0, 1, prog_result(4'd0, 2'd0));
        // Single point, two settling ticks, highest threshold: never locked.
        add_config(make_cfg(16'd2, 16'd3, 16'hFFFF, 4'd0, 2'd0));
        add_item(OP_START, 1'b0, 1, prog_result(4'd0, 2'd0));
        add_item(OP_TICK, 1'b0, 0);
        add_item(OP_TICK, 1'b0, 0);
        add_item(OP_TICK, 1'b1, 0);
        add_item(OP_TICK, 1'b1, 0);
        add_item(OP_TICK, 1'b1, 2, verdict_result(4'd0, 2'd0, 1'b0, 16'd3),
                 done_result());
        // Widest sweep limits; these rows are left to the predictor.
        add_config(make_cfg(16'd1, 16'd2, 16'd1, 4'd15, 2'd3));
        add_item(OP_START, 1'b1);
        add_item(OP_TICK, 1'b0);
        add_item(OP_TICK, 1'b1);
        add_item(OP_TICK, 1'b1);
        add_item(OP_TICK, 1'b0);
        add_item(OP_TICK, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                wait_until_idle();
                write_config(directed_rows[i].cfg);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].n_typed,
                          directed_rows[i].r0, directed_rows[i].r1);
            end
        end

        // Full 64-point sweep, two results per tick, while the receiver holds
        // off for a long stretch: the result queue fills and input stalls.
        wait_until_idle();
        write_config(make_cfg(16'd0, 16'd1, 16'd0, 4'd15, 2'd3));
        hold_off_req = 1'b1;
        send_item(make_item(OP_START, 1'b0));
        repeat (70) send_item(make_item(OP_TICK, 1'($urandom_range(0, 1))));

        // Longest settling time loaded into the countdown.
        wait_until_idle();
        write_config(make_cfg(16'hFFFF, 16'd1, 16'd0, 4'd0, 2'd0));
        send_item(make_item(OP_START, 1'b1));
        repeat (20) send_item(make_item(OP_TICK, 1'b1));

        // One long point with every sample locked, sent back to back: the
        // count climbs to the sample total and just clears the threshold.
        wait_until_idle();
        write_config(make_cfg(16'd0, 16'd100, 16'd99, 4'd0, 2'd0));
        burst_mode = 1'b1;
        send_item(make_item(OP_START, 1'b0));
        repeat (100) send_item(make_item(OP_TICK, 1'b1));
        burst_mode = 1'b0;

        // Random phases: mostly ticks into a running sweep, a few restarts,
        // and some ignored ticks when idle. Registers change between phases,
        // which may land in the middle of a sweep or a point.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            wait_until_idle();
            write_config(draw_config());
            burst_mode  = ($urandom_range(0, 3) == 0);
            lock_pct    = $urandom_range(0, 100);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS && counted < RANDOM_ITEMS) begin
                smp = ($urandom_range(0, 99) < lock_pct);
                if (sweep_phase == PH_IDLE) begin
                    op = ($urandom_range(0, 4) == 0) ? OP_TICK : OP_START;
                end else begin
                    op = ($urandom_range(0, 49) == 0) ? OP_START : OP_TICK;
                end
                if (!(sweep_phase == PH_IDLE && op == OP_TICK)) begin
                    counted++;
                    phase_count++;
                end
                send_item(make_item(op, smp));
            end
        end
        burst_mode = 1'b0;

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
